// File: sv/rtch_pkg.sv
// Shared types, constants and fixed-point helpers for the closest-hit ray/triangle block.
package rtch_pkg;

  localparam int FB = 16;
  localparam int CW = 32;
  localparam int UW = FB + 2;
  localparam int DW = 31;
  localparam int EW = 16;
  localparam int NREG = 8;
  localparam int RIW = 3;

  localparam logic [RIW-1:0] REG_START_X = 3'd0;
  localparam logic [RIW-1:0] REG_START_Y = 3'd1;
  localparam logic [RIW-1:0] REG_START_Z = 3'd2;
  localparam logic [RIW-1:0] REG_DIR_X   = 3'd3;
  localparam logic [RIW-1:0] REG_DIR_Y   = 3'd4;
  localparam logic [RIW-1:0] REG_DIR_Z   = 3'd5;
  localparam logic [RIW-1:0] REG_LENGTH  = 3'd6;
  localparam logic [RIW-1:0] REG_EPSILON = 3'd7;

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

  // Accumulator operand selects.
  typedef enum logic [1:0] {
    ACC_CLR,
    ACC_ADD,
    ACC_SUB,
    ACC_HOLD
  } acc_op_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_PREP,
    ST_END,
    ST_DIFF,
    ST_SP,
    ST_EP,
    ST_SIDE,
    ST_PX,
    ST_PY,
    ST_PZ,
    ST_DET,
    ST_DETCHK,
    ST_UNUM,
    ST_UDIV,
    ST_UCHK,
    ST_QX,
    ST_QY,
    ST_QZ,
    ST_VNUM,
    ST_VDIV,
    ST_VCHK,
    ST_PTX,
    ST_PTY,
    ST_PTZ,
    ST_DEPTH,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    state_t      step;
    logic        load;
    logic        div_start;
    logic        update;
    logic        clear;
  } cmd_t;

  typedef struct packed {
    logic same_side;
    logic det_bad;
    logic u_bad;
    logic v_bad;
    logic div_busy;
  } status_t;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                             input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SMAX)) return SMAX;
    if (s < 65'(SMIN)) return SMIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                             input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(SMAX)) return SMAX;
    if (s < 65'(SMIN)) return SMIN;
    return s[63:0];
  endfunction

endpackage

// File: sv/rtch_mul.sv
// Signed Q48.16 multiplier: floor of the product, saturated to 64 bits, summed from 32-bit partial products.
module rtch_mul import rtch_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic                done,
  output logic signed [63:0]  p
);

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic         zero;
  logic [1:0]   idx;
  logic [2:0]   cnt;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] q;
  logic         over;
  logic         frac_nz;
  logic [63:0]  qm;

  always_comb begin
    pp = 64'(ma[idx[0]*32 +: 32]) * 64'(mb[idx[1]*32 +: 32]);
    pp_sh = 128'(pp) << (32 * (int'(idx[0]) + int'(idx[1])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma <= a[63] ? 64'(-a) : 64'(a);
        mb <= b[63] ? 64'(-b) : 64'(b);
        neg <= a[63] ^ b[63];
        zero <= (a == 64'sd0) || (b == 64'sd0);
        acc <= 128'd0;
        idx <= 2'd0;
        cnt <= 3'd4;
      end else if (cnt != 3'd0) begin
        acc <= acc + pp_sh;
        idx <= idx + 2'd1;
        cnt <= cnt - 3'd1;
        done <= (cnt == 3'd1);
      end
    end
  end

  always_comb begin
    q = acc >> FB;
    frac_nz = acc[FB-1:0] != '0;
    over = q[127:64] != '0;
    qm = q[63:0];
    if (neg && frac_nz) begin
      if (qm == '1) over = 1'b1;
      qm = qm + 64'd1;
    end
    if (zero) p = 64'sd0;
    else if (neg) p = (over || qm[63]) ? SMIN : -$signed(qm);
    else p = (over || qm[63]) ? SMAX : $signed(qm);
  end

endmodule

// File: sv/rtch_div.sv
// Restoring divider: truncated n * 2^16 / d with saturation, one quotient bit per cycle.
module rtch_div import rtch_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [63:0]  n,
  input  logic signed [63:0]  d,
  output logic                busy,
  output logic signed [63:0]  q
);

  logic [79:0] dvd;
  logic [63:0] md;
  logic [64:0] rem;
  logic [79:0] quo;
  logic        neg;
  logic [6:0]  cnt;
  logic [64:0] trial;
  logic [63:0] mn;

  assign mn = n[63] ? 64'(-n) : 64'(n);
  assign trial = {rem[63:0], dvd[79]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 7'd0;
    end else if (start) begin
      dvd <= {mn, {FB{1'b0}}};
      md <= d[63] ? 64'(-d) : 64'(d);
      neg <= n[63] ^ d[63];
      rem <= '0;
      quo <= '0;
      cnt <= 7'd80;
    end else if (cnt != 7'd0) begin
      dvd <= dvd << 1;
      if (trial >= 65'(md)) begin
        rem <= trial - 65'(md);
        quo <= {quo[78:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[78:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
    end
  end

  assign busy = start || (cnt != 7'd0);

  always_comb begin
    if (quo == '0) q = 64'sd0;
    else if (neg) q = (quo[79:64] != '0 || quo[63]) ? SMIN : -$signed(quo[63:0]);
    else q = (quo[79:64] != '0 || quo[63]) ? SMAX : $signed(quo[63:0]);
  end

endmodule

// File: sv/rtch_datapath.sv
// Datapath: operand registers, shared multiplier and divider, and the kept best hit.
module rtch_datapath import rtch_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  mul_done,
  input  logic                  mul_start,
  input  logic [1:0]            term,
  input  logic                  cfg_we,
  input  logic [RIW-1:0]        cfg_index,
  input  logic [CW-1:0]         cfg_data,
  input  logic signed [CW-1:0]  in_v [9],
  input  logic signed [UW-1:0]  in_n [3],
  output logic                  best_valid,
  output logic                  repl,
  output logic signed [CW-1:0]  best_point [3],
  output logic signed [UW-1:0]  best_normal [3],
  output logic [DW-1:0]         best_depth
);

  logic signed [63:0] start_r [3];
  logic signed [63:0] dir [3];
  logic [DW-1:0]      length;
  logic [EW-1:0]      eps;

  logic signed [63:0] v [3][3];
  logic signed [63:0] nrm [3];
  logic signed [63:0] ds [3];
  logic signed [63:0] de [3];
  logic signed [63:0] e1 [3];
  logic signed [63:0] e2 [3];
  logic signed [63:0] pv [3];
  logic signed [63:0] qv [3];
  logic signed [63:0] ptv [3];
  logic signed [63:0] sp;
  logic signed [63:0] det;
  logic signed [63:0] uq;
  logic signed [63:0] vq;
  logic signed [63:0] acc;
  logic signed [63:0] ma;
  logic signed [63:0] mb;
  logic signed [63:0] mp;
  logic signed [63:0] dq;
  logic signed [63:0] dn;
  logic               neg_term;
  logic               set_acc;
  logic signed [63:0] one;
  logic signed [63:0] w;
  logic signed [63:0] acc_next;
  logic [63:0]        dmag;
  logic [DW-1:0]      dep;
  logic signed [63:0] ptc;
  logic               div_busy;

  assign one = 64'sd1 <<< FB;
  assign w = ssub(ssub(one, uq), vq);

  rtch_mul u_mul (.clk, .rst, .start(mul_start), .a(ma), .b(mb), .done(mul_done), .p(mp));
  rtch_div u_div (.clk, .rst, .start(cmd.div_start), .n(dn), .d(det), .busy(div_busy), .q(dq));

  // Operand selection for each sequenced step; term picks one product of the step's two or three.
  always_comb begin
    ma = 64'sd0;
    mb = 64'sd0;
    neg_term = 1'b0;
    dn = acc;
    case (cmd.step)
      ST_END: begin
        ma = dir[term];
        mb = 64'(length);
      end
      ST_SP: begin
        ma = nrm[term];
        mb = ds[term];
      end
      ST_EP: begin
        ma = nrm[term];
        mb = de[term];
      end
      ST_PX, ST_PY, ST_PZ: begin
        // p = e2 x dir
        case (cmd.step)
          ST_PX: begin
            ma = term[0] ? e2[2] : e2[1];
            mb = term[0] ? dir[1] : dir[2];
          end
          ST_PY: begin
            ma = term[0] ? e2[0] : e2[2];
            mb = term[0] ? dir[2] : dir[0];
          end
          default: begin
            ma = term[0] ? e2[1] : e2[0];
            mb = term[0] ? dir[0] : dir[1];
          end
        endcase
        neg_term = term[0];
      end
      ST_DET: begin
        ma = e1[term];
        mb = pv[term];
      end
      ST_UNUM: begin
        ma = ds[term];
        mb = pv[term];
      end
      ST_QX, ST_QY, ST_QZ: begin
        // q = e1 x ds
        case (cmd.step)
          ST_QX: begin
            ma = term[0] ? e1[2] : e1[1];
            mb = term[0] ? ds[1] : ds[2];
          end
          ST_QY: begin
            ma = term[0] ? e1[0] : e1[2];
            mb = term[0] ? ds[2] : ds[0];
          end
          default: begin
            ma = term[0] ? e1[1] : e1[0];
            mb = term[0] ? ds[0] : ds[1];
          end
        endcase
        neg_term = term[0];
      end
      ST_VNUM: begin
        ma = dir[term];
        mb = qv[term];
      end
      ST_PTX, ST_PTY, ST_PTZ: begin
        ma = v[term][cmd.step == ST_PTX ? 0 : (cmd.step == ST_PTY ? 1 : 2)];
        mb = (term == 2'd0) ? w : ((term == 2'd1) ? uq : vq);
      end
      ST_DEPTH: begin
        ma = dir[term];
        mb = ssub(ptv[term], start_r[term]);
      end
      default: begin
        ma = 64'sd0;
        mb = 64'sd0;
      end
    endcase
  end

  assign set_acc = mul_done && (term == 2'd0);
  assign acc_next = set_acc ? (neg_term ? ssub(64'sd0, mp) : mp)
                            : (neg_term ? ssub(acc, mp) : sadd(acc, mp));

  always_comb begin
    ptc = acc;
    if (acc > 64'sd2147483647) ptc = 64'sd2147483647;
    else if (acc < -64'sd2147483648) ptc = -64'sd2147483648;
    dmag = acc[63] ? 64'(-acc) : 64'(acc);
    dep = (dmag > 64'h7FFF_FFFF) ? {DW{1'b1}} : dmag[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) start_r[i] <= 64'sd0;
      dir[0] <= 64'sd1 <<< FB;
      dir[1] <= 64'sd0;
      dir[2] <= 64'sd0;
      length <= '0;
      eps <= EW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X: start_r[0] <= 64'($signed(cfg_data));
        REG_START_Y: start_r[1] <= 64'($signed(cfg_data));
        REG_START_Z: start_r[2] <= 64'($signed(cfg_data));
        REG_DIR_X:   dir[0] <= 64'($signed(cfg_data[UW-1:0]));
        REG_DIR_Y:   dir[1] <= 64'($signed(cfg_data[UW-1:0]));
        REG_DIR_Z:   dir[2] <= 64'($signed(cfg_data[UW-1:0]));
        REG_LENGTH:  length <= cfg_data[DW-1:0];
        REG_EPSILON: eps <= cfg_data[EW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) v[i][j] <= 64'(in_v[i*3+j]);
        nrm[i] <= 64'(in_n[i]);
      end
    end
    if (mul_done) acc <= acc_next;
    case (cmd.step)
      ST_PREP: begin
        for (int j = 0; j < 3; j++) begin
          e1[j] <= ssub(v[1][j], v[0][j]);
          e2[j] <= ssub(v[2][j], v[0][j]);
          ds[j] <= ssub(start_r[j], v[0][j]);
        end
      end
      default: ;
    endcase
    if (mul_done && cmd.step == ST_END) de[term] <= ssub(sadd(start_r[term], mp), v[0][term]);
    if (cmd.step == ST_EP && !mul_done && term == 2'd0) sp <= acc;
    if (cmd.step == ST_PY && !mul_done && term == 2'd0) pv[0] <= acc;
    if (cmd.step == ST_PZ && !mul_done && term == 2'd0) pv[1] <= acc;
    if (cmd.step == ST_DET && !mul_done && term == 2'd0) pv[2] <= acc;
    if (cmd.step == ST_DETCHK) det <= acc;
    if (cmd.step == ST_UCHK) uq <= dq;
    if (cmd.step == ST_QY && !mul_done && term == 2'd0) qv[0] <= acc;
    if (cmd.step == ST_QZ && !mul_done && term == 2'd0) qv[1] <= acc;
    if (cmd.step == ST_VNUM && !mul_done && term == 2'd0) qv[2] <= acc;
    if (cmd.step == ST_VCHK) vq <= dq;
    if (cmd.step == ST_PTY && !mul_done && term == 2'd0) ptv[0] <= ptc;
    if (cmd.step == ST_PTZ && !mul_done && term == 2'd0) ptv[1] <= ptc;
    if (cmd.step == ST_DEPTH && !mul_done && term == 2'd0) ptv[2] <= ptc;
  end

  always_comb begin
    status.same_side = (acc > 0 && sp > 0) || (acc < 0 && sp < 0);
    status.det_bad = (acc == 64'sd0) ||
                     (acc > -$signed(64'(eps)) && acc < $signed(64'(eps)));
    status.u_bad = dq < 64'sd0 || dq > one;
    status.v_bad = dq < 64'sd0 || sadd(uq, dq) > one;
    status.div_busy = div_busy;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      best_valid <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        best_point[j] <= '0;
        best_normal[j] <= '0;
      end
      best_depth <= '0;
      repl <= 1'b0;
    end else begin
      if (cmd.load) repl <= 1'b0;
      if (cmd.update && (!best_valid || dep < best_depth)) begin
        best_valid <= 1'b1;
        repl <= 1'b1;
        for (int j = 0; j < 3; j++) begin
          best_point[j] <= ptv[j][CW-1:0];
          best_normal[j] <= nrm[j][UW-1:0];
        end
        best_depth <= dep;
      end
    end
  end

endmodule

// File: sv/rtch_ctrl.sv
// Controller: sequences the multiply and divide steps for one triangle and the result transfer.
module rtch_ctrl import rtch_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic       out_fire,
  input  logic       cfg_clear,
  input  status_t    status,
  input  logic       mul_done,
  output logic       mul_start,
  output logic [1:0] term,
  output cmd_t       cmd,
  output logic       in_ready,
  output logic       out_valid
);

  state_t     state;
  state_t     state_next;
  logic [1:0] term_next;
  logic       issued;
  logic       issued_next;
  logic [1:0] nterms;
  logic       is_mul;
  logic       last;

  always_comb begin
    is_mul = 1'b0;
    nterms = 2'd3;
    case (state)
      ST_END, ST_SP, ST_EP, ST_DET, ST_UNUM, ST_VNUM, ST_PTX, ST_PTY, ST_PTZ, ST_DEPTH:
        is_mul = 1'b1;
      ST_PX, ST_PY, ST_PZ, ST_QX, ST_QY, ST_QZ: begin
        is_mul = 1'b1;
        nterms = 2'd2;
      end
      default: ;
    endcase
    last = mul_done && (term == nterms - 2'd1);
  end

  always_comb begin
    state_next = state;
    term_next = term;
    issued_next = issued;
    if (is_mul) begin
      if (!issued) issued_next = 1'b1;
      else if (mul_done) begin
        issued_next = 1'b0;
        term_next = last ? 2'd0 : term + 2'd1;
      end
    end
    case (state)
      ST_IDLE:   if (in_fire) state_next = ST_PREP;
      ST_PREP:   state_next = ST_END;
      ST_END:    if (last) state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_SP;
      ST_SP:     if (last) state_next = ST_EP;
      ST_EP:     if (last) state_next = ST_SIDE;
      ST_SIDE:   state_next = ST_PX;
      ST_PX:     if (last) state_next = ST_PY;
      ST_PY:     if (last) state_next = ST_PZ;
      ST_PZ:     if (last) state_next = ST_DET;
      ST_DET:    if (last) state_next = ST_DETCHK;
      ST_DETCHK: state_next = ST_UNUM;
      ST_UNUM:   if (last) state_next = ST_UDIV;
      ST_UDIV:   if (!status.div_busy) state_next = ST_UCHK;
      ST_UCHK:   state_next = ST_QX;
      ST_QX:     if (last) state_next = ST_QY;
      ST_QY:     if (last) state_next = ST_QZ;
      ST_QZ:     if (last) state_next = ST_VNUM;
      ST_VNUM:   if (last) state_next = ST_VDIV;
      ST_VDIV:   if (!status.div_busy) state_next = ST_VCHK;
      ST_VCHK:   state_next = status.v_bad ? ST_OUT : ST_PTX;
      ST_PTX:    if (last) state_next = ST_PTY;
      ST_PTY:    if (last) state_next = ST_PTZ;
      ST_PTZ:    if (last) state_next = ST_DEPTH;
      ST_DEPTH:  if (last) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_OUT:    if (out_fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
    if (state == ST_SIDE && status.same_side) state_next = ST_OUT;
    if (state == ST_DETCHK && status.det_bad) state_next = ST_OUT;
    if (state == ST_UCHK && status.u_bad) state_next = ST_OUT;
  end

  always_comb begin
    cmd.step = state;
    cmd.load = in_fire;
    cmd.div_start = (state == ST_UDIV || state == ST_VDIV) && !issued;
    cmd.update = (state == ST_UPDATE);
    cmd.clear = cfg_clear;
    mul_start = is_mul && !issued;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      term <= 2'd0;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      term <= term_next;
      if (state == ST_UDIV || state == ST_VDIV) issued <= (state_next == state);
      else issued <= issued_next;
    end
  end

endmodule

// File: sv/ray_triangle_closest_hit.sv
// Top level of the closest-hit ray/triangle block.
// One triangle at a time: a transfer on the input starts a sequence of products on one
// shared multiplier, 42 for a triangle that reaches the hit point, and up to two divisions
// on an 80-bit restoring divider. A triangle rejected at the plane test or a later test
// goes straight to its result and skips the remaining steps. The result then waits for its
// transfer before the next triangle is taken. Any configuration write clears the kept hit.
module ray_triangle_closest_hit import rtch_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [RIW-1:0]       cfg_index,
  input  logic [CW-1:0]        cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] vertex0_x,
  input  logic signed [CW-1:0] vertex0_y,
  input  logic signed [CW-1:0] vertex0_z,
  input  logic signed [CW-1:0] vertex1_x,
  input  logic signed [CW-1:0] vertex1_y,
  input  logic signed [CW-1:0] vertex1_z,
  input  logic signed [CW-1:0] vertex2_x,
  input  logic signed [CW-1:0] vertex2_y,
  input  logic signed [CW-1:0] vertex2_z,
  input  logic signed [UW-1:0] face_normal_x,
  input  logic signed [UW-1:0] face_normal_y,
  input  logic signed [UW-1:0] face_normal_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit_found,
  output logic                 replaced,
  output logic signed [CW-1:0] point_x,
  output logic signed [CW-1:0] point_y,
  output logic signed [CW-1:0] point_z,
  output logic signed [UW-1:0] normal_x,
  output logic signed [UW-1:0] normal_y,
  output logic signed [UW-1:0] normal_z,
  output logic [DW-1:0]        hit_depth
);

  cmd_t               cmd;
  status_t            status;
  logic               mul_done;
  logic               mul_start;
  logic [1:0]         term;
  logic signed [CW-1:0] in_v [9];
  logic signed [UW-1:0] in_n [3];
  logic signed [CW-1:0] bp [3];
  logic signed [UW-1:0] bn [3];
  logic               rdy;
  logic               vld;

  assign in_v = '{vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
                  vertex2_x, vertex2_y, vertex2_z};
  assign in_n = '{face_normal_x, face_normal_y, face_normal_z};

  rtch_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(in_valid && rdy),
    .out_fire(vld && out_ready),
    .cfg_clear(cfg_we),
    .status, .mul_done, .mul_start, .term, .cmd,
    .in_ready(rdy), .out_valid(vld)
  );

  rtch_datapath u_dp (
    .clk, .rst, .cmd, .status, .mul_done, .mul_start, .term,
    .cfg_we, .cfg_index, .cfg_data, .in_v, .in_n,
    .best_valid(hit_found), .repl(replaced),
    .best_point(bp), .best_normal(bn), .best_depth(hit_depth)
  );

  assign in_ready = rdy;
  assign out_valid = vld;
  assign point_x = bp[0];
  assign point_y = bp[1];
  assign point_z = bp[2];
  assign normal_x = bn[0];
  assign normal_y = bn[1];
  assign normal_z = bn[2];

endmodule
